### design/fcs_pkg.sv
// shared types and codes for the ftp control sequencer
`default_nettype none

package fcs_pkg;

	localparam logic [9:0] CODE_PRE_LO  = 10'd100;
	localparam logic [9:0] CODE_DONE_LO = 10'd200;
	localparam logic [9:0] CODE_MID_LO  = 10'd300;
	localparam logic [9:0] CODE_MID_HI  = 10'd400;
	localparam logic [9:0] CODE_PASV    = 10'd227;

	typedef enum logic [2:0] {
		EV_START   = 3'd0,
		EV_REPLY   = 3'd1,
		EV_DOPEN   = 3'd2,
		EV_DCLOSE  = 3'd3,
		EV_TIMEOUT = 3'd4,
		EV_CANCEL  = 3'd5,
		EV_LOST    = 3'd6
	} fcs_ev_t;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'd0,
		ST_GREET     = 4'd1,
		ST_USER      = 4'd2,
		ST_PASS      = 4'd3,
		ST_SYST      = 4'd4,
		ST_CWD       = 4'd5,
		ST_TYPE      = 4'd6,
		ST_PASV      = 4'd7,
		ST_PASV_OPEN = 4'd8,
		ST_XSTART    = 4'd9,
		ST_XEND      = 4'd10,
		ST_RNFR      = 4'd11,
		ST_RNTO      = 4'd12,
		ST_SIMPLE    = 4'd13,
		ST_DRAIN     = 4'd14
	} fcs_stage_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_CONNECT  = 4'd1,
		OP_LIST     = 4'd2,
		OP_UPLOAD   = 4'd3,
		OP_DOWNLOAD = 4'd4,
		OP_MKDIR    = 4'd5,
		OP_DELFILE  = 4'd6,
		OP_DELDIR   = 4'd7,
		OP_RENAME   = 4'd8,
		OP_SIZE     = 4'd9,
		OP_NOOP     = 4'd10
	} fcs_op_t;

	typedef enum logic [4:0] {
		CMD_NONE = 5'd0,
		CMD_USER = 5'd1,
		CMD_PASS = 5'd2,
		CMD_SYST = 5'd3,
		CMD_CWD  = 5'd4,
		CMD_TYPE = 5'd5,
		CMD_PASV = 5'd6,
		CMD_LIST = 5'd7,
		CMD_RETR = 5'd8,
		CMD_STOR = 5'd9,
		CMD_MKD  = 5'd10,
		CMD_DELE = 5'd11,
		CMD_RMD  = 5'd12,
		CMD_RNFR = 5'd13,
		CMD_RNTO = 5'd14,
		CMD_SIZE = 5'd15,
		CMD_NOOP = 5'd16
	} fcs_cmd_t;

	typedef enum logic [3:0] {
		WHY_NONE       = 4'd0,
		WHY_REFUSED    = 4'd1,
		WHY_LOGIN      = 4'd2,
		WHY_FOLDER     = 4'd3,
		WHY_BINARY     = 4'd4,
		WHY_PASSIVE    = 4'd5,
		WHY_BAD_PASV   = 4'd6,
		WHY_XFER_REFUSED = 4'd7,
		WHY_XFER_FAILED  = 4'd8,
		WHY_RENAME     = 4'd9,
		WHY_COMMAND    = 4'd10,
		WHY_CANCELLED  = 4'd11,
		WHY_TIMEOUT    = 4'd12,
		WHY_LOST       = 4'd13,
		WHY_LOCAL_FILE = 4'd14,
		WHY_EMPTY      = 4'd15
	} fcs_why_t;

	typedef enum logic [1:0] {
		LK_DOWN       = 2'd0,
		LK_CONNECTING = 2'd1,
		LK_READY      = 2'd2,
		LK_BUSY       = 2'd3
	} fcs_link_t;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] request_op;
		logic       is_noop;
		logic [9:0] reply_code;
		logic       passive_ok;
		logic       local_file_ok;
	} fcs_in_t;

	typedef struct packed {
		fcs_stage_t stage;
		fcs_op_t    current_op;
		logic       busy;
		logic       data_closed;
		logic       final_seen;
		logic       upload_primed;
		fcs_link_t  link;
	} fcs_state_t;

	typedef struct packed {
		fcs_cmd_t  command;
		logic      open_control;
		logic      open_data;
		logic      start_upload;
		logic      finished;
		logic      succeeded;
		fcs_why_t  fail_reason;
		logic      listing_ready;
		logic      size_ready;
		logic      restart_timer;
		logic      abort_link;
		fcs_link_t link_status;
	} fcs_res_t;

endpackage

`default_nettype wire

### design/fcs_step.sv
// next-state and result logic for one event
`default_nettype none

module fcs_step
	import fcs_pkg::*;
(
	input  fcs_in_t    ev,
	input  fcs_state_t cur,
	output fcs_state_t nxt,
	output fcs_res_t   res
);

	logic     is_pre, is_done, is_mid;
	logic     do_fin, fin_ok, go;
	fcs_why_t fin_why;
	fcs_op_t  op_v;
	fcs_state_t n;
	fcs_res_t   r;

	assign is_pre  = (ev.reply_code >= CODE_PRE_LO) && (ev.reply_code < CODE_DONE_LO);
	assign is_done = (ev.reply_code >= CODE_DONE_LO) && (ev.reply_code < CODE_MID_LO);
	assign is_mid  = (ev.reply_code >= CODE_MID_LO) && (ev.reply_code < CODE_MID_HI);

	always_comb begin
		n       = cur;
		r       = '0;
		do_fin  = 1'b0;
		fin_ok  = 1'b0;
		fin_why = WHY_NONE;
		go      = 1'b0;
		op_v    = OP_NONE;
		unique case (ev.func)
			EV_START: begin
				if (ev.request_op == OP_SIZE && ev.is_noop)
					op_v = OP_NOOP;
				else if (ev.request_op > OP_SIZE)
					op_v = OP_NONE;
				else
					op_v = fcs_op_t'(ev.request_op);
				if (!cur.busy) begin
					if (op_v == OP_CONNECT) begin
						r.abort_link = (cur.link != LK_DOWN) || (cur.stage == ST_DRAIN);
						n.stage = ST_IDLE;
						go = 1'b1;
					end else if (cur.link == LK_READY && cur.stage != ST_DRAIN) begin
						go = 1'b1;
					end
				end
				if (go) begin
					n.data_closed   = 1'b0;
					n.final_seen    = 1'b0;
					n.upload_primed = 1'b0;
					n.busy          = 1'b1;
					n.current_op    = op_v;
					n.link          = (op_v == OP_CONNECT) ? LK_CONNECTING : LK_BUSY;
					r.restart_timer = 1'b1;
					unique case (op_v)
						OP_CONNECT: begin
							n.stage = ST_GREET;
							r.open_control = 1'b1;
						end
						OP_LIST: begin
							n.stage = ST_CWD;
							r.command = CMD_CWD;
						end
						OP_UPLOAD, OP_DOWNLOAD: begin
							n.stage = ST_TYPE;
							r.command = CMD_TYPE;
						end
						OP_MKDIR: begin
							n.stage = ST_SIMPLE;
							r.command = CMD_MKD;
						end
						OP_DELFILE: begin
							n.stage = ST_SIMPLE;
							r.command = CMD_DELE;
						end
						OP_DELDIR: begin
							n.stage = ST_SIMPLE;
							r.command = CMD_RMD;
						end
						OP_RENAME: begin
							n.stage = ST_RNFR;
							r.command = CMD_RNFR;
						end
						OP_SIZE: begin
							n.stage = ST_SIMPLE;
							r.command = CMD_SIZE;
						end
						OP_NOOP: begin
							n.stage = ST_SIMPLE;
							r.command = CMD_NOOP;
						end
						default: begin
							n.current_op = OP_NONE;
							do_fin  = 1'b1;
							fin_why = WHY_EMPTY;
						end
					endcase
				end
			end
			EV_REPLY: begin
				unique case (cur.stage)
					ST_DRAIN: begin
						if (is_pre) begin
							r.restart_timer = 1'b1;
						end else begin
							n.stage = ST_IDLE;
							if (cur.link == LK_READY || cur.link == LK_BUSY)
								n.link = LK_READY;
						end
					end
					ST_GREET: begin
						if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_REFUSED;
						end else begin
							n.stage = ST_USER; r.command = CMD_USER; r.restart_timer = 1'b1;
						end
					end
					ST_USER: begin
						if (is_done) begin
							n.stage = ST_SYST; r.command = CMD_SYST; r.restart_timer = 1'b1;
						end else if (is_mid) begin
							n.stage = ST_PASS; r.command = CMD_PASS; r.restart_timer = 1'b1;
						end else begin
							do_fin = 1'b1; fin_why = WHY_LOGIN;
						end
					end
					ST_PASS: begin
						if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_LOGIN;
						end else begin
							n.stage = ST_SYST; r.command = CMD_SYST; r.restart_timer = 1'b1;
						end
					end
					ST_SYST: begin
						do_fin = 1'b1; fin_ok = 1'b1;
					end
					ST_CWD: begin
						if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_FOLDER;
						end else begin
							n.stage = ST_TYPE; r.command = CMD_TYPE; r.restart_timer = 1'b1;
						end
					end
					ST_TYPE: begin
						if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_BINARY;
						end else begin
							n.stage = ST_PASV; r.command = CMD_PASV; r.restart_timer = 1'b1;
						end
					end
					ST_PASV, ST_PASV_OPEN: begin
						if (ev.reply_code != CODE_PASV) begin
							do_fin = 1'b1; fin_why = WHY_PASSIVE;
						end else if (!ev.passive_ok) begin
							do_fin = 1'b1; fin_why = WHY_BAD_PASV;
						end else begin
							n.stage = ST_PASV_OPEN;
							r.open_data = 1'b1;
							r.restart_timer = 1'b1;
						end
					end
					ST_XSTART: begin
						if (is_pre) begin
							r.restart_timer = 1'b1;
							if (cur.current_op == OP_UPLOAD && !cur.upload_primed) begin
								n.upload_primed = 1'b1;
								r.start_upload = 1'b1;
							end
						end else if (is_done) begin
							n.stage = ST_XEND;
							n.final_seen = 1'b1;
							if (cur.data_closed) begin
								r.listing_ready = (cur.current_op == OP_LIST);
								do_fin = 1'b1; fin_ok = 1'b1;
							end
						end else begin
							do_fin = 1'b1; fin_why = WHY_XFER_REFUSED;
						end
					end
					ST_XEND: begin
						if (is_pre) begin
							r.restart_timer = 1'b1;
						end else if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_XFER_FAILED;
						end else begin
							n.final_seen = 1'b1;
							if (!cur.data_closed) begin
								r.restart_timer = 1'b1;
							end else begin
								r.listing_ready = (cur.current_op == OP_LIST);
								do_fin = 1'b1; fin_ok = 1'b1;
							end
						end
					end
					ST_RNFR: begin
						if (!is_mid) begin
							do_fin = 1'b1; fin_why = WHY_RENAME;
						end else begin
							n.stage = ST_RNTO; r.command = CMD_RNTO; r.restart_timer = 1'b1;
						end
					end
					ST_RNTO, ST_SIMPLE: begin
						if (!is_done) begin
							do_fin = 1'b1; fin_why = WHY_COMMAND;
						end else begin
							r.size_ready = (cur.current_op == OP_SIZE);
							do_fin = 1'b1; fin_ok = 1'b1;
						end
					end
					default: begin
						// unsolicited reply while idle
					end
				endcase
			end
			EV_DOPEN: begin
				if (cur.busy && cur.stage == ST_PASV_OPEN) begin
					n.stage = ST_XSTART;
					if (cur.current_op == OP_LIST) begin
						r.command = CMD_LIST;
						r.restart_timer = 1'b1;
					end else if (cur.current_op == OP_DOWNLOAD
							|| cur.current_op == OP_UPLOAD) begin
						if (!ev.local_file_ok) begin
							do_fin = 1'b1; fin_why = WHY_LOCAL_FILE;
						end else begin
							r.command = (cur.current_op == OP_DOWNLOAD) ? CMD_RETR : CMD_STOR;
							r.restart_timer = 1'b1;
						end
					end
				end
			end
			EV_DCLOSE: begin
				if (cur.busy && (cur.stage == ST_XSTART || cur.stage == ST_XEND)) begin
					n.data_closed = 1'b1;
					if (cur.stage == ST_XSTART) begin
						n.stage = ST_XEND;
						r.restart_timer = 1'b1;
					end else if (cur.final_seen) begin
						r.listing_ready = (cur.current_op == OP_LIST);
						do_fin = 1'b1; fin_ok = 1'b1;
					end
				end
			end
			EV_TIMEOUT: begin
				// no completion report while draining
				if (cur.stage != ST_DRAIN && cur.busy) begin
					r.finished    = 1'b1;
					r.fail_reason = WHY_TIMEOUT;
				end
				n.busy       = 1'b0;
				n.stage      = ST_IDLE;
				n.current_op = OP_NONE;
				n.link       = LK_DOWN;
				r.abort_link = 1'b1;
			end
			EV_CANCEL: begin
				if (cur.busy) begin
					n.busy       = 1'b0;
					n.current_op = OP_NONE;
					// a reply is still owed unless the channel may not be up yet
					if (cur.stage != ST_IDLE && cur.stage != ST_GREET) begin
						n.stage = ST_DRAIN;
						r.restart_timer = 1'b1;
					end else begin
						n.stage = ST_IDLE;
					end
					r.finished    = 1'b1;
					r.fail_reason = WHY_CANCELLED;
					if (cur.link == LK_READY || cur.link == LK_BUSY)
						n.link = LK_READY;
				end
			end
			EV_LOST: begin
				if (cur.busy) begin
					r.finished    = 1'b1;
					r.fail_reason = WHY_LOST;
				end
				n.busy       = 1'b0;
				n.stage      = ST_IDLE;
				n.current_op = OP_NONE;
				n.link       = LK_DOWN;
			end
			default: begin
			end
		endcase

		// completion always comes last in a step
		if (do_fin) begin
			if ((n.current_op == OP_CONNECT && fin_ok) || n.link == LK_READY
					|| n.link == LK_BUSY)
				n.link = LK_READY;
			n.busy          = 1'b0;
			n.stage         = ST_IDLE;
			n.current_op    = OP_NONE;
			r.finished      = 1'b1;
			r.succeeded     = fin_ok;
			r.fail_reason   = fin_ok ? WHY_NONE : fin_why;
			r.restart_timer = 1'b0;
		end
		r.link_status = n.link;
	end

	assign nxt = n;
	assign res = r;

endmodule

`default_nettype wire

### design/fcs_out_reg.sv
// result register with its master-side handshake
`default_nettype none

module fcs_out_reg
	import fcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fcs_res_t in_res,
	output logic     out_valid,
	input  logic     out_ready,
	output fcs_res_t out_res
);

	logic     valid_q;
	fcs_res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire

### design/ftp_control_sequencer_unit.sv
// top level of the ftp control sequencer
//
// channel  dir  tuser         tdata                      meaning
// s_axis   in   func[2:0]     op, noop, code, pasv, file  one event
// m_axis   out  -             command .. link_status     one result per event
//
// every event gives exactly one result on m_tvalid, via the input register and then the
// result register; one event per cycle sustained while m_tready is high, through the single state update step.
// the event is held in an input register and the session state updates as it
// moves into the result register.
// reset clears the session to idle and disconnected; no clearing pass.
// a stall on m_tready holds the result; one more event may wait in the input register.
`default_nettype none

module ftp_control_sequencer_unit
	import fcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] request_op, [4] is_noop, [14:5] reply_code, [15] passive_ok,
	// [16] local_file_ok, [23:17] zero
	input  logic [23:0] s_tdata,
	// [2:0] func
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] command, [5] open_control, [6] open_data, [7] start_upload,
	// [8] finished, [9] succeeded, [13:10] fail_reason, [14] listing_ready,
	// [15] size_ready, [16] restart_timer, [17] abort_link, [19:18] link_status,
	// [23:20] zero
	output logic [23:0] m_tdata
);

	logic       valid_s1;
	fcs_in_t    ev_s1;
	fcs_state_t state_q;
	fcs_state_t state_nxt;
	fcs_res_t   step_res;
	fcs_res_t   out_res;
	logic       ob_ready;
	logic       advance;

	assign advance  = valid_s1 && ob_ready;
	assign s_tready = !valid_s1 || ob_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_s1.func          <= s_tuser;
			ev_s1.request_op    <= s_tdata[3:0];
			ev_s1.is_noop       <= s_tdata[4];
			ev_s1.reply_code    <= s_tdata[14:5];
			ev_s1.passive_ok    <= s_tdata[15];
			ev_s1.local_file_ok <= s_tdata[16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stage         <= ST_IDLE;
			state_q.current_op    <= OP_NONE;
			state_q.busy          <= 1'b0;
			state_q.data_closed   <= 1'b0;
			state_q.final_seen    <= 1'b0;
			state_q.upload_primed <= 1'b0;
			state_q.link          <= LK_DOWN;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	fcs_step u_step (
		.ev  (ev_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (step_res)
	);

	fcs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ob_ready),
		.in_res    (step_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {4'b0000, out_res.link_status, out_res.abort_link,
		out_res.restart_timer, out_res.size_ready, out_res.listing_ready,
		out_res.fail_reason, out_res.succeeded, out_res.finished,
		out_res.start_upload, out_res.open_data, out_res.open_control,
		out_res.command};

endmodule

`default_nettype wire

### design/fcs_checker.sv
// port-level checks for the ftp control sequencer, bound to the top level
`default_nettype none

module fcs_checker
	import fcs_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a reason code only comes with a failed completion
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[13:10] != WHY_NONE) |-> m_tdata[8] && !m_tdata[9])
		else $error("fail reason without failed completion");

	a_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8])
		else $error("success without completion");

	// opening the control link leaves the status at connecting
	a_connect: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[19:18] == LK_CONNECTING)
		else $error("open control with wrong link status");

	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |->
			(m_tdata[19:18] == LK_DOWN || m_tdata[19:18] == LK_CONNECTING))
		else $error("abort with link still up");

endmodule

bind ftp_control_sequencer_unit fcs_checker u_fcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
